// ===== rtl/core/vnorm_pkg.sv =====
// ----------------------------------------------------------------------------
// vnorm_pkg
// Shared constants for the vector normalize unit.
// ----------------------------------------------------------------------------
package vnorm_pkg;

    localparam int unsigned IN_WIDTH_DEF  = 16;
    localparam int unsigned FRAC_BITS_DEF = 14;

endpackage

// ===== rtl/core/vnorm_if.sv =====
// ----------------------------------------------------------------------------
// vnorm_if
// Request channels of the vector normalize unit: vector in, unit vector out.
// ----------------------------------------------------------------------------
interface vnorm_vec_if #(
    parameter int unsigned W = vnorm_pkg::IN_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] vec_x;
    logic signed [W-1:0] vec_y;
    logic signed [W-1:0] vec_z;

    modport source (output valid, vec_x, vec_y, vec_z, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface vnorm_unit_if #(
    parameter int unsigned F = vnorm_pkg::FRAC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic signed [F+1:0] unit_x;
    logic signed [F+1:0] unit_y;
    logic signed [F+1:0] unit_z;
    logic                zero_vector;

    modport source (output valid, unit_x, unit_y, unit_z, zero_vector, input ready);
    modport sink   (input valid, unit_x, unit_y, unit_z, zero_vector, output ready);
endinterface

// ===== rtl/core/vnorm_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// vnorm_sqrt_cell
// One root digit of the square root chain: shift in two radicand bits, try
// the subtract, append one root bit.
// ----------------------------------------------------------------------------
module vnorm_sqrt_cell #(
    parameter int unsigned RW     = 31,
    parameter int unsigned SIDE_W = 51
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [RW+1:0]     i_rem,
    input  logic [RW-1:0]     i_root,
    input  logic [2*RW-1:0]   i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [RW+1:0]     o_rem,
    output logic [RW-1:0]     o_root,
    output logic [2*RW-1:0]   o_rad,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    logic [RW+1:0]     r_rem;
    logic [RW-1:0]     r_root;
    logic [2*RW-1:0]   r_rad;
    logic [SIDE_W-1:0] r_side;

    logic [RW+1:0]     rem_sh;
    logic [RW+1:0]     trial;
    logic              take;
    logic [RW+1:0]     n_rem;
    logic [RW-1:0]     n_root;

    always_comb begin
        rem_sh = {i_rem[RW-1:0], i_rad[2*RW-1 -: 2]};
        trial  = {i_root, 2'b01};
        take   = (rem_sh >= trial);
        n_rem  = take ? (rem_sh - trial) : rem_sh;
        n_root = {i_root[RW-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= {i_rad[2*RW-3:0], 2'b00};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_side  = r_side;

endmodule

// ===== rtl/core/vnorm_div_cell.sv =====
// ----------------------------------------------------------------------------
// vnorm_div_cell
// One quotient bit for all three components: compare each remainder with the
// root shifted by this cell's weight, subtract where it fits.
// ----------------------------------------------------------------------------
module vnorm_div_cell #(
    parameter int unsigned W  = 16,
    parameter int unsigned F  = 14,
    parameter int unsigned RW = 31,
    parameter int unsigned K  = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  logic [RW-1:0]      i_root,
    input  logic [2:0]         i_neg,
    input  logic [3*(W+2*F)-1:0] i_rem,
    input  logic [3*(F+1)-1:0] i_quo,
    output logic               o_valid,
    output logic [RW-1:0]      o_root,
    output logic [2:0]         o_neg,
    output logic [3*(W+2*F)-1:0] o_rem,
    output logic [3*(F+1)-1:0] o_quo
);

    localparam int unsigned DW = W + 2*F;
    localparam int unsigned CW = RW + F + 1;
    localparam int unsigned QW = F + 1;

    logic               r_valid;
    logic [RW-1:0]      r_root;
    logic [2:0]         r_neg;
    logic [3*DW-1:0]    r_rem;
    logic [3*QW-1:0]    r_quo;

    logic [CW-1:0]      dsh;
    logic [3*DW-1:0]    n_rem;
    logic [3*QW-1:0]    n_quo;

    always_comb begin
        logic [CW-1:0] remx;
        logic          fit;
        dsh = CW'(i_root) << K;
        for (int c = 0; c < 3; c++) begin
            remx = CW'(i_rem[c*DW +: DW]);
            fit  = (remx >= dsh);
            n_rem[c*DW +: DW] = fit ? DW'(remx - dsh) : i_rem[c*DW +: DW];
            n_quo[c*QW +: QW] = {i_quo[c*QW +: QW-1], fit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_root <= i_root;
            r_neg  <= i_neg;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_root  = r_root;
    assign o_neg   = r_neg;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule

// ===== rtl/core/vector3_normalize_unit.sv =====
// ----------------------------------------------------------------------------
// vector3_normalize_unit
// Unit vector of a signed 3D integer vector, components in Q2.F fixed point.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                    | handshake
//  i_vec     | in  | vec_x, vec_y, vec_z (IN_WIDTH, signed)     | valid/ready
//  o_unit    | out | unit_x, unit_y, unit_z (F+2), zero_vector  | valid/ready
//
//  One request enters per cycle while o_unit is not stalled; results leave in
//  order, one per cycle. The pipeline is the front registers, the square root
//  chain (one cell per root bit), the divide chain (one cell per quotient bit)
//  and the output register.
//  Reset clears every valid bit in the pipeline; payload is not reset.
//  A stall on o_unit freezes the whole chain and drops i_vec.ready; with the
//  output register empty the chain keeps advancing.
// ----------------------------------------------------------------------------
module vector3_normalize_unit #(
    parameter int unsigned IN_WIDTH  = vnorm_pkg::IN_WIDTH_DEF,
    parameter int unsigned FRAC_BITS = vnorm_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vnorm_vec_if.sink     i_vec,
    vnorm_unit_if.source  o_unit
);

    localparam int unsigned W      = IN_WIDTH;
    localparam int unsigned F      = FRAC_BITS;
    localparam int unsigned SW     = 2*W + 2;        // sum of squares
    localparam int unsigned RW     = W + 1 + F;      // root bits
    localparam int unsigned DW     = W + 2*F;        // divide remainder
    localparam int unsigned QW     = F + 1;          // quotient bits
    localparam int unsigned OW     = F + 2;          // output width
    localparam int unsigned SIDE_W = 3*W + 3;        // magnitudes and signs

    // One global advance: the chain moves whenever the output register frees.
    logic adv;

    logic                r_out_valid;
    logic signed [OW-1:0] r_ux, r_uy, r_uz;
    logic                r_zero;

    assign adv         = !r_out_valid || o_unit.ready;
    assign i_vec.ready = adv;

    // ---- front: magnitudes, squares, sum ----
    logic                 r_a_valid, r_b_valid, r_c_valid;
    logic [W-1:0]         r_a_mag [3];
    logic [2:0]           r_a_neg, r_b_neg, r_c_neg;
    logic [2*W-1:0]       r_b_sq  [3];
    logic [W-1:0]         r_b_mag [3];
    logic [W-1:0]         r_c_mag [3];
    logic [SW-1:0]        r_c_sum;

    logic [W-1:0] in_c [3];
    assign in_c[0] = i_vec.vec_x;
    assign in_c[1] = i_vec.vec_y;
    assign in_c[2] = i_vec.vec_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_vec.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                // Most negative input folds to its magnitude as unsigned W bits.
                r_a_mag[c] <= in_c[c][W-1] ? (~in_c[c] + W'(1)) : in_c[c];
                r_a_neg[c] <= in_c[c][W-1];
                r_b_sq[c]  <= r_a_mag[c] * r_a_mag[c];
                r_b_mag[c] <= r_a_mag[c];
                r_c_mag[c] <= r_b_mag[c];
            end
            r_b_neg <= r_a_neg;
            r_c_neg <= r_b_neg;
            r_c_sum <= SW'(r_b_sq[0]) + SW'(r_b_sq[1]) + SW'(r_b_sq[2]);
        end
    end

    // ---- square root chain: one cell per root bit ----
    logic              sq_valid [RW+1];
    logic [RW+1:0]     sq_rem   [RW+1];
    logic [RW-1:0]     sq_root  [RW+1];
    logic [2*RW-1:0]   sq_rad   [RW+1];
    logic [SIDE_W-1:0] sq_side  [RW+1];

    assign sq_valid[0] = r_c_valid;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_rad[0]   = {r_c_sum, {(2*F){1'b0}}};
    assign sq_side[0]  = {r_c_neg, r_c_mag[2], r_c_mag[1], r_c_mag[0]};

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        vnorm_sqrt_cell #(
            .RW     (RW),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (sq_valid[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_rad   (sq_rad[g]),
            .i_side  (sq_side[g]),
            .o_valid (sq_valid[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_rad   (sq_rad[g+1]),
            .o_side  (sq_side[g+1])
        );
    end

    // ---- divide chain: quotient bit weights F down to 0 ----
    logic              dv_valid [QW+1];
    logic [RW-1:0]     dv_root  [QW+1];
    logic [2:0]        dv_neg   [QW+1];
    logic [3*DW-1:0]   dv_rem   [QW+1];
    logic [3*QW-1:0]   dv_quo   [QW+1];

    assign dv_valid[0] = sq_valid[RW];
    assign dv_root[0]  = sq_root[RW];
    assign dv_neg[0]   = sq_side[RW][SIDE_W-1 -: 3];
    for (genvar c = 0; c < 3; c++) begin : g_seed
        assign dv_rem[0][c*DW +: DW] = {sq_side[RW][c*W +: W], {(2*F){1'b0}}};
    end
    assign dv_quo[0] = '0;

    for (genvar g = 0; g < QW; g++) begin : g_div
        vnorm_div_cell #(
            .W  (W),
            .F  (F),
            .RW (RW),
            .K  (F - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (dv_valid[g]),
            .i_root  (dv_root[g]),
            .i_neg   (dv_neg[g]),
            .i_rem   (dv_rem[g]),
            .i_quo   (dv_quo[g]),
            .o_valid (dv_valid[g+1]),
            .o_root  (dv_root[g+1]),
            .o_neg   (dv_neg[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_quo   (dv_quo[g+1])
        );
    end

    // ---- output register: sign restore, zero vector ----
    // The root is at least |c| * 2^F, so each quotient stays within 2^F.
    logic          fin_zero;
    logic [OW-1:0] fin_u [3];

    always_comb begin
        logic [OW-1:0] q;
        fin_zero = (dv_root[QW] == '0);
        for (int c = 0; c < 3; c++) begin
            q = OW'(dv_quo[QW][c*QW +: QW]);
            if (fin_zero) begin
                fin_u[c] = '0;
            end else if (dv_neg[QW][c]) begin
                fin_u[c] = ~q + OW'(1);
            end else begin
                fin_u[c] = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= dv_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ux   <= fin_u[0];
            r_uy   <= fin_u[1];
            r_uz   <= fin_u[2];
            r_zero <= fin_zero;
        end
    end

    assign o_unit.valid       = r_out_valid;
    assign o_unit.unit_x      = r_ux;
    assign o_unit.unit_y      = r_uy;
    assign o_unit.unit_z      = r_uz;
    assign o_unit.zero_vector = r_zero;

endmodule

// ===== rtl/core/vnorm_chk.sv =====
// ----------------------------------------------------------------------------
// vnorm_chk
// Port checks for the vector normalize unit, bound to the top level.
// ----------------------------------------------------------------------------
module vnorm_chk #(
    parameter int unsigned F = vnorm_pkg::FRAC_BITS_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_in_ready,
    input logic signed [F+1:0] i_ux,
    input logic signed [F+1:0] i_uy,
    input logic signed [F+1:0] i_uz,
    input logic                i_zero
);

    localparam logic signed [F+1:0] ONE  = (F+2)'(1) << F;
    localparam logic signed [F+1:0] MONE = -((F+2)'(1) << F);

    // Hold a stalled result: valid, unit_x and zero_vector must stay.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_ux) && $stable(i_zero))
        else $error("result changed under stall");

    // Drop input ready only while a result is stalled.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input blocked without output stall");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_zero |-> i_ux == '0 && i_uy == '0 && i_uz == '0)
        else $error("zero vector with nonzero components");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_ux <= ONE && i_ux >= MONE && i_uy <= ONE && i_uy >= MONE
                        && i_uz <= ONE && i_uz >= MONE)
        else $error("component beyond unit range");

endmodule

bind vector3_normalize_unit vnorm_chk #(
    .F (FRAC_BITS)
) u_vnorm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_unit.valid),
    .i_out_ready (o_unit.ready),
    .i_in_ready  (i_vec.ready),
    .i_ux        (o_unit.unit_x),
    .i_uy        (o_unit.unit_y),
    .i_uz        (o_unit.unit_z),
    .i_zero      (o_unit.zero_vector)
);

// ===== dv/vnorm_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnorm_tb_if
// Testbench-side view of the vector normalize request channels.
// ----------------------------------------------------------------------------
// The block's own interfaces (vnorm_vec_if, vnorm_unit_if) carry valid, ready
// and the payload with source and sink modports; the testbench instantiates
// them directly, so this file only holds the shared request and result records.
package vnorm_tb_pkg;

    typedef struct packed {
        logic signed [15:0] vec_x;
        logic signed [15:0] vec_y;
        logic signed [15:0] vec_z;
    } t_vec_req;

    typedef struct packed {
        logic signed [15:0] unit_x;
        logic signed [15:0] unit_y;
        logic signed [15:0] unit_z;
        logic               zero_vector;
    } t_unit_res;

endpackage

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vector3_normalize_unit.
// ----------------------------------------------------------------------------
// Every vector request sent is run through a local predictor (integer square
// root of the scaled length, then a truncating, saturating divide per
// component) and queued. A checker compares each unit-vector request that
// leaves the block against the oldest queued prediction, field by field.
// Both sides idle at random; one phase holds the output off for a long
// stretch so the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FRAC      = vnorm_pkg::FRAC_BITS_DEF;
    localparam int LATENCY   = 3 + (vnorm_pkg::IN_WIDTH_DEF + FRAC + 1) + (FRAC + 1) + 1;
    localparam int MAX_WAIT  = 18;
    localparam int LONG_HOLD = 200;
    localparam int CYCLE_CAP = 400000;

    logic i_clk;
    logic i_rst_n;

    vnorm_vec_if  #(.W(vnorm_pkg::IN_WIDTH_DEF)) vec_ch ();
    vnorm_unit_if #(.F(FRAC))                    unit_ch ();

    vector3_normalize_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (vec_ch),
        .o_unit  (unit_ch)
    );

    // expected unit vectors, oldest first
    vnorm_tb_pkg::t_unit_res pending_units[$];
    int        fail_count;
    int        sent_count;
    int        checked_count;
    int        zero_seen;
    int        cycle_count;
    bit        hold_output;   // forces ready low for the long-stall phase

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // Predictor: floor square root of a 64-bit value, bit by bit.
    // ------------------------------------------------------------------------
    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Divide one component by the length, truncate toward zero, clamp to 1.0.
    function automatic logic signed [15:0] scale_component(longint c,
                                                           longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        mag = (c < 0) ? longint'(-c) : longint'(c);
        q   = (mag << (2 * FRAC)) / len;
        if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
        if (c < 0) q = -q;
        return q[15:0];
    endfunction

    function automatic vnorm_tb_pkg::t_unit_res normalize_vector(vnorm_tb_pkg::t_vec_req v);
        vnorm_tb_pkg::t_unit_res u;
        longint          x;
        longint          y;
        longint          z;
        longint unsigned sum_sq;
        longint unsigned len;
        x = v.vec_x;
        y = v.vec_y;
        z = v.vec_z;
        sum_sq = x * x + y * y + z * z;
        if (sum_sq == 0) begin
            u = '0;
            u.zero_vector = 1'b1;
            return u;
        end
        len = root_floor(sum_sq << (2 * FRAC));
        if (len == 0) len = 1;
        u.unit_x = scale_component(x, len);
        u.unit_y = scale_component(y, len);
        u.unit_z = scale_component(z, len);
        u.zero_vector = 1'b0;
        return u;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: idle for the given gap, then hold the request until taken.
    // Valid stays up into a request that follows with no gap.
    // ------------------------------------------------------------------------
    task automatic send_vector(vnorm_tb_pkg::t_vec_req v, int gap);
        if (gap > 0) begin
            vec_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        vec_ch.valid <= 1'b1;
        vec_ch.vec_x <= v.vec_x;
        vec_ch.vec_y <= v.vec_y;
        vec_ch.vec_z <= v.vec_z;
        pending_units.push_back(normalize_vector(v));
        sent_count++;
        do @(posedge i_clk); while (!vec_ch.ready);
    endtask

    task automatic send_random_gap(vnorm_tb_pkg::t_vec_req v);
        // about a third of requests go back to back
        send_vector(v, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_WAIT));
    endtask

    function automatic vnorm_tb_pkg::t_vec_req make_vec(int x, int y, int z);
        vnorm_tb_pkg::t_vec_req v;
        v.vec_x = 16'(x);
        v.vec_y = 16'(y);
        v.vec_z = 16'(z);
        return v;
    endfunction

    // pick a component: full range, small, medium, or near an extreme
    function automatic logic signed [15:0] rand_component();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 16'hffff));
            1:       return 16'($signed($urandom_range(0, 16)) - 8);
            2:       return 16'(($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000)
                                ^ $urandom_range(0, 15));
            default: return 16'($signed($urandom_range(0, 600)) - 300);
        endcase
    endfunction

    // Drop valid, then wait until every prediction has been checked.
    task automatic wait_drained();
        vec_ch.valid <= 1'b0;
        while (pending_units.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Checker: compare each accepted result with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && unit_ch.valid && unit_ch.ready) begin
            vnorm_tb_pkg::t_unit_res exp_u;
            if (pending_units.size() == 0) begin
                $error("unexpected result x=%0d y=%0d z=%0d zero=%0b", unit_ch.unit_x,
                       unit_ch.unit_y, unit_ch.unit_z, unit_ch.zero_vector);
                fail_count++;
            end else begin
                exp_u = pending_units.pop_front();
                checked_count++;
                if (exp_u.zero_vector) zero_seen++;
                if (unit_ch.unit_x !== exp_u.unit_x) begin
                    $error("unit_x expected %0d got %0d", exp_u.unit_x, unit_ch.unit_x);
                    fail_count++;
                end
                if (unit_ch.unit_y !== exp_u.unit_y) begin
                    $error("unit_y expected %0d got %0d", exp_u.unit_y, unit_ch.unit_y);
                    fail_count++;
                end
                if (unit_ch.unit_z !== exp_u.unit_z) begin
                    $error("unit_z expected %0d got %0d", exp_u.unit_z, unit_ch.unit_z);
                    fail_count++;
                end
                if (unit_ch.zero_vector !== exp_u.zero_vector) begin
                    $error("zero_vector expected %0b got %0b", exp_u.zero_vector,
                           unit_ch.zero_vector);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: draw a stall length per result; stretches of steady ready too.
    initial begin
        int stall;
        unit_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_output) begin
                unit_ch.ready <= 1'b0;
                @(posedge i_clk);
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
                if ($urandom_range(0, 9) < 3) stall = 0;
                if (stall != 0) begin
                    unit_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                unit_ch.ready <= 1'b1;
                do @(posedge i_clk); while (!unit_ch.valid && !hold_output);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_extremes();
        vnorm_tb_pkg::t_vec_req dir[$];
        dir.push_back(make_vec(0, 0, 0));             // zero vector
        dir.push_back(make_vec(1, 0, 0));
        dir.push_back(make_vec(0, -1, 0));
        dir.push_back(make_vec(0, 0, 32767));
        dir.push_back(make_vec(-32768, 0, 0));
        dir.push_back(make_vec(-32768, -32768, -32768));
        dir.push_back(make_vec(32767, 32767, 32767));
        dir.push_back(make_vec(32767, -32768, 32767));
        dir.push_back(make_vec(1, 1, 1));             // length rounds down
        dir.push_back(make_vec(-1, 1, -1));
        dir.push_back(make_vec(3, 4, 0));
        dir.push_back(make_vec(1, 32767, 0));
        dir.push_back(make_vec(-1, -1, -32768));
        dir.push_back(make_vec(0, 0, 0));
        dir.push_back(make_vec(2, 2, 1));
        dir.push_back(make_vec(21845, -10922, 5461));
        dir.push_back(make_vec(-21846, 10921, -5462));
        foreach (dir[i]) send_random_gap(dir[i]);
        wait_drained();
    endtask

    task automatic test_random_stream(int count);
        repeat (count) begin
            if ($urandom_range(0, 49) == 0)
                send_random_gap(make_vec(0, 0, 0));
            else
                send_random_gap(make_vec(rand_component(), rand_component(),
                                         rand_component()));
        end
    endtask

    // Hold the output off while requests keep coming, then release.
    task automatic test_backpressure();
        fork
            begin
                hold_output = 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_output = 1'b0;
            end
            repeat (90) send_vector(make_vec(rand_component(), rand_component(),
                                             rand_component()), 0);
        join
        // pause until every prediction has been checked
        wait_drained();
    endtask

    initial begin
        fail_count    = 0;
        sent_count    = 0;
        checked_count = 0;
        zero_seen     = 0;
        cycle_count   = 0;
        hold_output   = 1'b0;
        i_rst_n       <= 1'b0;
        vec_ch.valid  <= 1'b0;
        vec_ch.vec_x  <= '0;
        vec_ch.vec_y  <= '0;
        vec_ch.vec_z  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_random_stream(270);
        test_backpressure();
        test_random_stream(270);

        wait_drained();
        repeat (2 * LATENCY) @(posedge i_clk);
        $display("Covered %0d vectors (%0d zero), %0d results checked, long output stall.",
                 sent_count, zero_seen, checked_count);
        if (fail_count == 0 && pending_units.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== vector3_normalize_unit.f =====
rtl/core/vnorm_pkg.sv
rtl/core/vnorm_if.sv
rtl/core/vnorm_sqrt_cell.sv
rtl/core/vnorm_div_cell.sv
rtl/core/vector3_normalize_unit.sv
rtl/core/vnorm_chk.sv
dv/vnorm_tb_if.sv
dv/testbench.sv
